/* src/slpc_pkg.sv */
// shared types and constants of the status LED pattern controller
package slpc_pkg;

  // default tick counter width
  localparam int unsigned TICK_WIDTH_DEF = 32;

  // configuration field widths
  localparam int unsigned PERIOD_W = 10;
  localparam int unsigned TOGGLE_W = 8;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = PERIOD_W;

  // configuration reset values
  localparam logic                DUAL_CAN_RST     = 1'b0;
  localparam logic [PERIOD_W-1:0] SHORT_PERIOD_RST = PERIOD_W'(70);
  localparam logic [PERIOD_W-1:0] ON_TIME_RST      = PERIOD_W'(30);
  localparam logic [PERIOD_W-1:0] LONG_PERIOD_RST  = PERIOD_W'(270);
  localparam logic [TOGGLE_W-1:0] SEND_TOGGLES_RST = TOGGLE_W'(10);

  // fast toggle fires when the phase counter wraps past its last value
  localparam logic [2:0] FAST_LAST = 3'd4;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DUAL_CAN     = 3'd0,
    CFG_SHORT_PERIOD = 3'd1,
    CFG_ON_TIME      = 3'd2,
    CFG_LONG_PERIOD  = 3'd3,
    CFG_SEND_TOGGLES = 3'd4
  } cfg_idx_e;

  // positions of the LEDs in the level vector
  localparam int unsigned LED_RED    = 0;
  localparam int unsigned LED_YELLOW = 1;
  localparam int unsigned LED_BLUE   = 2;
  localparam int unsigned LED_GREEN  = 3;

  // one tick with its status flags
  typedef struct packed {
    logic               can1_fault;
    logic               can2_fault;
    logic               shell_alarm;
    logic               antenna_fault;
    logic               lte_powered;
    logic               sim_ok;
    logic [COUNT_W-1:0] send_count;
    logic               server_linked;
    logic [COUNT_W-1:0] nmea_count;
    logic               gnss_fix_valid;
    logic               setup_mode;
  } tick_in_t;

  // LED levels after one tick
  typedef struct packed {
    logic red_led;
    logic yellow_led;
    logic blue_led;
    logic green_led;
  } led_out_t;

endpackage

/* src/slpc_stream_if.sv */
// valid/ready stream interface carrying one payload per transaction
interface slpc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/status_led_pattern_controller.sv */
// top level of the status LED pattern controller
// Each input transaction is one timer tick with status flags; each tick yields exactly one
// output transaction holding the four LED levels after that tick. An accepted tick is held
// in an input register; when the result slot is free, one pass of compare/add logic updates
// the tick count, deadlines, burst counter and LED levels, which form the result register.
// One tick per cycle is sustained while the output side does not stall, and the result is
// offered from the result register. While the output side stalls the result register
// holds, so backpressure stops the input after one buffered tick. The cost of the pass is
// set by the TICK_WIDTH-bit deadline compares and adds. Configuration writes take effect on
// the next tick and must only be issued while no tick is in flight.
module status_led_pattern_controller #(
  parameter int unsigned TICK_WIDTH = slpc_pkg::TICK_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  slpc_stream_if.sink                      in_i,
  slpc_stream_if.source                    out_o,
  input  logic                             cfg_we_i,
  input  logic [slpc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [slpc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import slpc_pkg::*;

  localparam int unsigned TW = TICK_WIDTH;

  // configuration registers
  logic                dual_can_q;
  logic [PERIOD_W-1:0] short_period_q, on_time_q, long_period_q;
  logic [TOGGLE_W-1:0] send_toggles_q;

  // pipeline control
  logic     s1_valid_q, out_valid_q, adv;
  tick_in_t s1_q;

  // block state
  logic [TW-1:0]       tick_q, tick_d;
  logic [2:0]          fast_phase_q, fast_phase_d;
  logic [TW-1:0]       red_off_q, red_off_d, red_on_q, red_on_d;
  logic [TW-1:0]       yel_off_q, yel_off_d, yel_on_q, yel_on_d;
  logic [TW-1:0]       grn_off_q, grn_off_d, grn_on_q, grn_on_d;
  logic [TW-1:0]       blue_dl_q, blue_dl_d;
  logic [COUNT_W-1:0]  seen_send_q, seen_send_d, seen_nmea_q, seen_nmea_d;
  logic [TOGGLE_W-1:0] burst_q, burst_d;
  logic [3:0]          led_q, led_d;

  // derived per-tick terms
  logic                fast, link_fault;
  logic [PERIOD_W-1:0] yel_period;
  logic [TW-1:0]       on_end;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dual_can_q     <= DUAL_CAN_RST;
      short_period_q <= SHORT_PERIOD_RST;
      on_time_q      <= ON_TIME_RST;
      long_period_q  <= LONG_PERIOD_RST;
      send_toggles_q <= SEND_TOGGLES_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DUAL_CAN:     dual_can_q     <= cfg_data_i[0];
        CFG_SHORT_PERIOD: short_period_q <= cfg_data_i[PERIOD_W-1:0];
        CFG_ON_TIME:      on_time_q      <= cfg_data_i[PERIOD_W-1:0];
        CFG_LONG_PERIOD:  long_period_q  <= cfg_data_i[PERIOD_W-1:0];
        CFG_SEND_TOGGLES: send_toggles_q <= cfg_data_i[TOGGLE_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: the tick in the input register moves on when the result slot is free
  assign adv         = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || adv;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = '{red_led:    led_q[LED_RED],
                         yellow_led: led_q[LED_YELLOW],
                         blue_led:   led_q[LED_BLUE],
                         green_led:  led_q[LED_GREEN]};

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_q <= in_i.data;
    end
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // tick advance and shared terms
  assign tick_d       = tick_q + TW'(1);
  assign fast_phase_d = (fast_phase_q >= FAST_LAST) ? 3'd0 : fast_phase_q + 3'd1;
  assign fast         = (fast_phase_d == 3'd0);
  assign link_fault   = dual_can_q ? (s1_q.can1_fault || s1_q.can2_fault) : s1_q.can1_fault;
  assign yel_period   = s1_q.server_linked ? long_period_q : short_period_q;
  assign on_end       = tick_d + TW'(on_time_q);

  // per-LED pattern selection
  always_comb begin
    led_d       = led_q;
    red_off_d   = red_off_q;
    red_on_d    = red_on_q;
    yel_off_d   = yel_off_q;
    yel_on_d    = yel_on_q;
    grn_off_d   = grn_off_q;
    grn_on_d    = grn_on_q;
    blue_dl_d   = blue_dl_q;
    seen_send_d = seen_send_q;
    seen_nmea_d = seen_nmea_q;
    burst_d     = burst_q;

    // yellow: power and sim faults, send burst, then network blink
    if (!s1_q.lte_powered || !s1_q.sim_ok) begin
      led_d[LED_YELLOW] = 1'b1;
    end else if (s1_q.send_count != seen_send_q) begin
      if (fast) begin
        led_d[LED_YELLOW] = !led_q[LED_YELLOW];
        if (burst_q >= send_toggles_q) begin
          seen_send_d = s1_q.send_count;
          burst_d     = '0;
        end else begin
          burst_d = burst_q + TOGGLE_W'(1);
        end
      end
    end else if (yel_off_q <= tick_d) begin
      yel_off_d         = tick_d + TW'(yel_period);
      yel_on_d          = on_end;
      led_d[LED_YELLOW] = 1'b1;
    end else if (tick_d >= yel_on_q) begin
      led_d[LED_YELLOW] = 1'b0;
    end

    // blue: pulse on a new sentence count
    if (s1_q.nmea_count != seen_nmea_q) begin
      led_d[LED_BLUE] = 1'b1;
      seen_nmea_d     = s1_q.nmea_count;
      blue_dl_d       = on_end;
    end else if (!s1_q.gnss_fix_valid && (blue_dl_q <= tick_d)) begin
      led_d[LED_BLUE] = 1'b0;
    end

    // green: setup toggle or heartbeat
    if (s1_q.setup_mode) begin
      if (fast) begin
        led_d[LED_GREEN] = !led_q[LED_GREEN];
      end
    end else if (grn_off_q <= tick_d) begin
      grn_off_d        = tick_d + TW'(short_period_q);
      grn_on_d         = on_end;
      led_d[LED_GREEN] = 1'b1;
    end else if (tick_d >= grn_on_q) begin
      led_d[LED_GREEN] = 1'b0;
    end

    // red: link fault, shell alarm, antenna blink
    if (link_fault) begin
      if (fast) begin
        led_d[LED_RED] = !led_q[LED_RED];
      end
    end else if (s1_q.shell_alarm) begin
      led_d[LED_RED] = 1'b1;
    end else if (s1_q.antenna_fault) begin
      if (red_off_q <= tick_d) begin
        red_off_d      = tick_d + TW'(short_period_q);
        red_on_d       = on_end;
        led_d[LED_RED] = 1'b1;
      end else if (tick_d >= red_on_q) begin
        led_d[LED_RED] = 1'b0;
      end
    end else begin
      led_d[LED_RED] = 1'b0;
    end
  end

  // state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q       <= '0;
      fast_phase_q <= '0;
      red_off_q    <= '0;
      red_on_q     <= '0;
      yel_off_q    <= '0;
      yel_on_q     <= '0;
      grn_off_q    <= '0;
      grn_on_q     <= '0;
      blue_dl_q    <= '0;
      seen_send_q  <= '0;
      seen_nmea_q  <= '0;
      burst_q      <= '0;
      led_q        <= '0;
    end else if (adv) begin
      tick_q       <= tick_d;
      fast_phase_q <= fast_phase_d;
      red_off_q    <= red_off_d;
      red_on_q     <= red_on_d;
      yel_off_q    <= yel_off_d;
      yel_on_q     <= yel_on_d;
      grn_off_q    <= grn_off_d;
      grn_on_q     <= grn_on_d;
      blue_dl_q    <= blue_dl_d;
      seen_send_q  <= seen_send_d;
      seen_nmea_q  <= seen_nmea_d;
      burst_q      <= burst_d;
      led_q        <= led_d;
    end
  end

  // phase counter stays within its cycle of five
  assert property (@(posedge clk_i) disable iff (!rst_ni) fast_phase_q <= FAST_LAST)
    else $error("fast phase out of range");

  // every processed tick leaves a result to deliver
  assert property (@(posedge clk_i) disable iff (!rst_ni) adv |=> out_valid_q)
    else $error("processed tick produced no result");

  // tick count moves by exactly one per processed tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   adv |=> (tick_q == TW'($past(tick_q) + TW'(1))))
    else $error("tick count skipped");

  // setup mode only toggles green on fast ticks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (adv && s1_q.setup_mode && !fast)
                   |=> (led_q[LED_GREEN] == $past(led_q[LED_GREEN])))
    else $error("green changed off a fast tick in setup mode");

endmodule

/* tb/tb_top.sv */
// self-checking testbench of the status LED pattern controller: directed table, then random ticks
module tb_top;
  import slpc_pkg::*;

  localparam int unsigned TW = TICK_WIDTH_DEF;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned TICKS_PER_SETTING = 110;
  localparam int unsigned SETTINGS_RUN = 5;

  typedef logic [TW-1:0] tick_t;

  // one row of the directed table
  typedef struct {
    tick_in_t    stim;
    int unsigned reps;
    bit          known;
    led_out_t    leds;
  } dir_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = CFG_DUAL_CAN;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  slpc_stream_if #(.payload_t(tick_in_t)) tick_if ();
  slpc_stream_if #(.payload_t(led_out_t)) led_if ();

  status_led_pattern_controller dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (tick_if),
    .out_o      (led_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // predictor copy of the registers
  logic                dual_can_q;
  logic [PERIOD_W-1:0] short_period_q;
  logic [PERIOD_W-1:0] on_time_q;
  logic [PERIOD_W-1:0] long_period_q;
  logic [TOGGLE_W-1:0] send_toggles_q;

  // predictor copy of the block state
  tick_t               ticks;
  logic [2:0]          phase5;
  tick_t               red_start, red_dark;
  tick_t               yel_start, yel_dark;
  tick_t               grn_start, grn_dark;
  tick_t               pulse_end;
  logic [COUNT_W-1:0]  sends_seen;
  logic [COUNT_W-1:0]  nmea_seen;
  logic [TOGGLE_W-1:0] toggles_done;
  logic [3:0]          levels;

  // expected LED levels, oldest first
  led_out_t            led_queue[$];

  // directed stimulus table
  dir_row_t            dir_rows[$];

  // sideband of the tick on the bus: a typed-in expectation from the table
  bit                  row_known = 1'b0;
  led_out_t            row_leds = '0;

  // running sender state of the random part
  tick_in_t            flow;
  bit                  no_idle = 1'b0;

  int unsigned         errors = 0;
  int unsigned         ticks_sent = 0;
  int unsigned         results_seen = 0;
  int unsigned         bursts_done = 0;
  int unsigned         pulses_started = 0;
  int unsigned         stall_cycles = 0;

  task automatic reset_model();
    dual_can_q     = DUAL_CAN_RST;
    short_period_q = SHORT_PERIOD_RST;
    on_time_q      = ON_TIME_RST;
    long_period_q  = LONG_PERIOD_RST;
    send_toggles_q = SEND_TOGGLES_RST;
    ticks        = '0;
    phase5       = '0;
    red_start    = '0;
    red_dark     = '0;
    yel_start    = '0;
    yel_dark     = '0;
    grn_start    = '0;
    grn_dark     = '0;
    pulse_end    = '0;
    sends_seen   = '0;
    nmea_seen    = '0;
    toggles_done = '0;
    levels       = '0;
  endtask

  // period/on-time blink held by a period start and a lit-end deadline
  function automatic void step_blink(input logic [1:0] led, inout tick_t start_at,
                                     inout tick_t dark_at, input tick_t period);
    if (start_at <= ticks) begin
      start_at    = ticks + period;
      dark_at     = ticks + tick_t'(on_time_q);
      levels[led] = 1'b1;
    end else if (ticks >= dark_at) begin
      levels[led] = 1'b0;
    end
  endfunction

  // advance one tick and return the LED levels after it
  function automatic led_out_t predict_leds(tick_in_t t);
    logic     fast;
    logic     link_down;
    led_out_t r;
    ticks  = ticks + 1'b1;
    phase5 = (phase5 >= FAST_LAST) ? 3'd0 : phase5 + 3'd1;
    fast   = (phase5 == 3'd0);

    // yellow: power and sim first, then send burst, then blink
    if (!t.lte_powered || !t.sim_ok) begin
      levels[LED_YELLOW] = 1'b1;
    end else if (t.send_count != sends_seen) begin
      if (fast) begin
        levels[LED_YELLOW] = ~levels[LED_YELLOW];
        if (toggles_done >= send_toggles_q) begin
          sends_seen   = t.send_count;
          toggles_done = '0;
          bursts_done++;
        end else begin
          toggles_done = toggles_done + 1'b1;
        end
      end
    end else if (t.server_linked) begin
      step_blink(2'(LED_YELLOW), yel_start, yel_dark, tick_t'(long_period_q));
    end else begin
      step_blink(2'(LED_YELLOW), yel_start, yel_dark, tick_t'(short_period_q));
    end

    // blue: pulse on each new sentence count
    if (t.nmea_count != nmea_seen) begin
      levels[LED_BLUE] = 1'b1;
      nmea_seen        = t.nmea_count;
      pulse_end        = ticks + tick_t'(on_time_q);
      pulses_started++;
    end else if (!t.gnss_fix_valid && pulse_end <= ticks) begin
      levels[LED_BLUE] = 1'b0;
    end

    // green: setup toggles, else heartbeat
    if (t.setup_mode) begin
      if (fast) levels[LED_GREEN] = ~levels[LED_GREEN];
    end else begin
      step_blink(2'(LED_GREEN), grn_start, grn_dark, tick_t'(short_period_q));
    end

    // red: link fault, shell alarm, antenna
    link_down = t.can1_fault || (dual_can_q && t.can2_fault);
    if (link_down) begin
      if (fast) levels[LED_RED] = ~levels[LED_RED];
    end else if (t.shell_alarm) begin
      levels[LED_RED] = 1'b1;
    end else if (t.antenna_fault) begin
      step_blink(2'(LED_RED), red_start, red_dark, tick_t'(short_period_q));
    end else begin
      levels[LED_RED] = 1'b0;
    end

    r.red_led    = levels[LED_RED];
    r.yellow_led = levels[LED_YELLOW];
    r.blue_led   = levels[LED_BLUE];
    r.green_led  = levels[LED_GREEN];
    return r;
  endfunction

  function automatic void check_level(string name, logic want, logic got);
    if (got !== want) begin
      $error("%s: expected %b, got %b", name, want, got);
      errors++;
    end
  endfunction

  // compare results, predict on accepted ticks, track register writes
  always @(posedge clk_i) begin : scoreboard
    led_out_t want;
    if (rst_ni) begin
      if (led_if.valid && led_if.ready) begin
        if (led_queue.size() == 0) begin
          $error("LED transaction %b with nothing expected", led_if.data);
          errors++;
        end else begin
          want = led_queue.pop_front();
          check_level("red_led", want.red_led, led_if.data.red_led);
          check_level("yellow_led", want.yellow_led, led_if.data.yellow_led);
          check_level("blue_led", want.blue_led, led_if.data.blue_led);
          check_level("green_led", want.green_led, led_if.data.green_led);
          results_seen++;
        end
      end
      if (tick_if.valid && tick_if.ready) begin
        want = predict_leds(tick_if.data);
        if (row_known) want = row_leds;
        led_queue.push_back(want);
        ticks_sent++;
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_DUAL_CAN:     dual_can_q = cfg_data_i[0];
          CFG_SHORT_PERIOD: short_period_q = cfg_data_i;
          CFG_ON_TIME:      on_time_q = cfg_data_i;
          CFG_LONG_PERIOD:  long_period_q = cfg_data_i;
          CFG_SEND_TOGGLES: send_toggles_q = cfg_data_i[TOGGLE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (tick_if.valid && tick_if.ready) || (led_if.valid && led_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // mostly short gaps, a few long ones, none while no_idle is set
  function automatic int unsigned draw_stall_cycles();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // result side backpressure
  initial begin : led_sink
    int unsigned hold;
    led_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      hold = draw_stall_cycles();
      if (hold != 0) begin
        led_if.ready = 1'b0;
        repeat (hold) @(negedge clk_i);
      end
      led_if.ready = 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
  end

  // one tick transaction, called and returning at a falling edge
  task automatic send_tick(tick_in_t stim, bit known, led_out_t leds);
    int unsigned gap;
    gap = draw_stall_cycles();
    if (gap != 0) begin
      tick_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    tick_if.valid = 1'b1;
    tick_if.data  = stim;
    row_known     = known;
    row_leds      = leds;
    do @(posedge clk_i); while (!tick_if.ready);
    @(negedge clk_i);
  endtask

  // append one row to the directed table
  function automatic void add_row(tick_in_t stim, int unsigned reps, bit known,
                                  led_out_t leds);
    dir_row_t row;
    row.stim  = stim;
    row.reps  = reps;
    row.known = known;
    row.leds  = leds;
    dir_rows.push_back(row);
  endfunction

  // hold the sender until every result is back and the block is idle
  task automatic wait_drained();
    tick_if.valid = 1'b0;
    while (led_queue.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
  endtask

  task automatic apply_setting(int unsigned which);
    wait_drained();
    case (which)
      1: begin
        // lower extremes
        cfg_write(CFG_DUAL_CAN, CFG_DATA_W'(1));
        cfg_write(CFG_SHORT_PERIOD, CFG_DATA_W'(1));
        cfg_write(CFG_ON_TIME, CFG_DATA_W'(1));
        cfg_write(CFG_LONG_PERIOD, CFG_DATA_W'(1));
        cfg_write(CFG_SEND_TOGGLES, CFG_DATA_W'(0));
      end
      2: begin
        // upper extremes
        cfg_write(CFG_DUAL_CAN, CFG_DATA_W'(0));
        cfg_write(CFG_SHORT_PERIOD, CFG_DATA_W'(1023));
        cfg_write(CFG_ON_TIME, CFG_DATA_W'(1023));
        cfg_write(CFG_LONG_PERIOD, CFG_DATA_W'(1023));
        cfg_write(CFG_SEND_TOGGLES, CFG_DATA_W'(255));
      end
      3: begin
        // short blinks and short bursts
        cfg_write(CFG_DUAL_CAN, CFG_DATA_W'(1));
        cfg_write(CFG_SHORT_PERIOD, CFG_DATA_W'($urandom_range(2, 40)));
        cfg_write(CFG_ON_TIME, CFG_DATA_W'($urandom_range(1, 20)));
        cfg_write(CFG_LONG_PERIOD, CFG_DATA_W'($urandom_range(5, 120)));
        cfg_write(CFG_SEND_TOGGLES, CFG_DATA_W'($urandom_range(0, 6)));
      end
      default: begin
        cfg_write(CFG_DUAL_CAN, CFG_DATA_W'($urandom_range(0, 1)));
        cfg_write(CFG_SHORT_PERIOD, CFG_DATA_W'($urandom_range(1, 200)));
        cfg_write(CFG_ON_TIME, CFG_DATA_W'($urandom_range(1, 200)));
        cfg_write(CFG_LONG_PERIOD, CFG_DATA_W'($urandom_range(1, 400)));
        cfg_write(CFG_SEND_TOGGLES, CFG_DATA_W'($urandom_range(0, 30)));
      end
    endcase
    cfg_we_i = 1'b0;
  endtask

  // a flag leaves its healthy value now and then and comes back after a while
  function automatic logic drift(logic now, logic good, int unsigned fail_pct);
    if (now == good) return ($urandom_range(0, 99) < fail_pct) ? ~good : good;
    return ($urandom_range(0, 99) < 20) ? good : now;
  endfunction

  // well-formed status stream with running counters, plus some noise
  function automatic tick_in_t next_random_tick();
    tick_in_t    noise;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      noise = tick_in_t'({$urandom, $urandom});
      return noise;
    end
    flow.can1_fault     = drift(flow.can1_fault, 1'b0, 3);
    flow.can2_fault     = drift(flow.can2_fault, 1'b0, 6);
    flow.shell_alarm    = drift(flow.shell_alarm, 1'b0, 3);
    flow.antenna_fault  = drift(flow.antenna_fault, 1'b0, 8);
    flow.lte_powered    = drift(flow.lte_powered, 1'b1, 2);
    flow.sim_ok         = drift(flow.sim_ok, 1'b1, 2);
    flow.server_linked  = drift(flow.server_linked, 1'b1, 5);
    flow.gnss_fix_valid = drift(flow.gnss_fix_valid, 1'b1, 10);
    flow.setup_mode     = drift(flow.setup_mode, 1'b0, 3);
    r = $urandom_range(0, 99);
    if (r < 3) flow.send_count = flow.send_count + COUNT_W'($urandom_range(1, 3));
    else if (r < 5) flow.send_count = COUNT_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 25) flow.nmea_count = flow.nmea_count + 1'b1;
    else if (r < 30) flow.nmea_count = COUNT_W'($urandom);
    return flow;
  endfunction

  initial begin : main
    tick_in_t    base;
    tick_in_t    t;
    led_out_t    leds;
    int unsigned s;
    int unsigned n;
    int unsigned i;
    int unsigned k;
    reset_model();
    tick_if.valid = 1'b0;
    tick_if.data  = '0;
    flow          = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // healthy status: powered, attached, fix valid, no faults
    base                = '0;
    base.lte_powered    = 1'b1;
    base.sim_ok         = 1'b1;
    base.gnss_fix_valid = 1'b1;

    // first tick after reset starts the yellow and green blinks
    leds = '{red_led: 1'b0, yellow_led: 1'b1, blue_led: 1'b0, green_led: 1'b1};
    add_row(base, 1, 1'b1, leds);
    // power loss, shell alarm, new sentence, setup mode, ignored second link
    t = base;
    t.lte_powered = 1'b0;
    t.shell_alarm = 1'b1;
    t.nmea_count  = '1;
    t.setup_mode  = 1'b1;
    t.can2_fault  = 1'b1;
    leds = '{red_led: 1'b1, yellow_led: 1'b1, blue_led: 1'b1, green_led: 1'b1};
    add_row(t, 1, 1'b1, leds);

    // link fault across a fast tick
    t = base;
    t.nmea_count = '1;
    t.can1_fault = 1'b1;
    add_row(t, 3, 1'b0, '0);
    // sim missing hides a new send count
    t = base;
    t.nmea_count = '1;
    t.sim_ok     = 1'b0;
    t.send_count = '1;
    add_row(t, 1, 1'b0, '0);
    // send burst with antenna blink on red
    t.sim_ok        = 1'b1;
    t.antenna_fault = 1'b1;
    add_row(t, 5, 1'b0, '0);
    // burst interrupted by power loss keeps its count
    t.lte_powered = 1'b0;
    add_row(t, 1, 1'b0, '0);
    // fix lost, setup toggles, server link
    t = base;
    t.nmea_count     = '1;
    t.gnss_fix_valid = 1'b0;
    t.setup_mode     = 1'b1;
    t.server_linked  = 1'b1;
    add_row(t, 4, 1'b0, '0);
    // every field at its top and at its bottom
    add_row('1, 1, 1'b0, '0);
    add_row('0, 1, 1'b0, '0);
    add_row('1, 1, 1'b0, '0);
    // healthy again, server linked
    t = base;
    t.nmea_count    = '1;
    t.send_count    = '1;
    t.server_linked = 1'b1;
    add_row(t, 3, 1'b0, '0);

    // walk the directed table
    for (i = 0; i < dir_rows.size(); i++) begin
      for (k = 0; k < dir_rows[i].reps; k++) begin
        send_tick(dir_rows[i].stim, dir_rows[i].known, dir_rows[i].leds);
      end
    end

    // random part over several register settings
    wait_drained();
    flow = t;
    for (s = 0; s < SETTINGS_RUN; s++) begin
      if (s != 0) apply_setting(s);
      for (n = 0; n < TICKS_PER_SETTING; n++) begin
        no_idle = (n >= 40 && n < 70);
        if (n == 80) wait_drained();
        send_tick(next_random_tick(), 1'b0, '0);
      end
    end
    no_idle = 1'b0;
    tick_if.valid = 1'b0;

    // let the last results drain
    while (led_queue.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("covered %0d ticks, %0d LED results checked, %0d register settings",
             ticks_sent, results_seen, SETTINGS_RUN);
    $display("send bursts completed: %0d, position pulses started: %0d",
             bursts_done, pulses_started);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* files.f */
src/slpc_pkg.sv
src/slpc_stream_if.sv
src/status_led_pattern_controller.sv
tb/tb_top.sv
